[hdl/adh_pkg.sv]
// Package for the per-axis position histogram: sizes, codes, queue command
// and configuration types, and the effective bin count helper.
// Depends on nothing; every other file of the block uses it.
package adh_pkg;

    // Storage sizes
    localparam int MAX_BINS   = 1024;
    localparam int COUNT_BITS = 32;
    localparam int BIN_BITS   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int PROD_BITS  = COUNT_BITS + 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Command queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_BITS = 5;
    localparam logic [2:0] REG_INV_BIN_WIDTH = 3'd0;
    localparam logic [2:0] REG_BINS_X        = 3'd1;
    localparam logic [2:0] REG_BINS_Y        = 3'd2;
    localparam logic [2:0] REG_BINS_Z        = 3'd3;
    localparam logic [2:0] REG_INV_VOLUME_X  = 3'd4;
    localparam logic [2:0] REG_INV_VOLUME_Y  = 3'd5;
    localparam logic [2:0] REG_INV_VOLUME_Z  = 3'd6;

    // Item kinds and axis codes
    localparam logic [1:0] KIND_PARTICLE = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;
    localparam logic [1:0] AXIS_X        = 2'd0;
    localparam logic [1:0] AXIS_Y        = 2'd1;
    localparam logic [1:0] AXIS_Z        = 2'd2;

    // Operation carried by a queued command
    typedef enum logic [1:0] {
        OP_PARTICLE,
        OP_READ,
        OP_CLEAR
    } t_op;

    // One queued command. A read puts its bin index in all three addresses.
    typedef struct packed {
        t_op                 op;
        logic [BIN_BITS-1:0] bin_x;
        logic [BIN_BITS-1:0] bin_y;
        logic [BIN_BITS-1:0] bin_z;
        logic [1:0]          axis;
        logic                oor;
    } t_cmd;

    // Configuration register set
    typedef struct packed {
        logic [31:0] inv_bin_width;
        logic [10:0] bins_x;
        logic [10:0] bins_y;
        logic [10:0] bins_z;
        logic [31:0] inv_volume_x;
        logic [31:0] inv_volume_y;
        logic [31:0] inv_volume_z;
    } t_cfg;

    // Back-end status seen by the front end
    typedef struct packed {
        logic init_busy;
    } t_back_sts;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PART_WR,
        BK_READ_MUL,
        BK_CLEAR
    } t_back_state;

    // A bins register of zero acts as one; above the storage it saturates.
    function automatic logic [31:0] eff_bins(input logic [10:0] breg);
        logic [31:0] n;
        if (breg == 11'd0) begin
            n = 32'd1;
        end else if (32'(breg) > 32'(MAX_BINS)) begin
            n = 32'(MAX_BINS);
        end else begin
            n = 32'(breg);
        end
        return n;
    endfunction

endpackage

[hdl/adh_front.sv]
// Front end of the histogram: accepts items, scales positions to bins,
// clamps them and checks reads, then pushes commands to the queue.
// Depends on adh_pkg.
module adh_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adh_pkg::t_cfg      i_cfg,
    input  adh_pkg::t_back_sts i_back_sts,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic [1:0]         i_axis,
    input  logic [9:0]         i_bin_index,
    input  logic               i_q_full,
    output logic               o_q_push,
    output adh_pkg::t_cmd      o_q_cmd
);

    logic        r_s1_vld;
    logic [1:0]  r_s1_kind;
    logic [31:0] r_s1_pos_x;
    logic [31:0] r_s1_pos_y;
    logic [31:0] r_s1_pos_z;
    logic [1:0]  r_s1_axis;
    logic [9:0]  r_s1_idx;

    logic        r_s2_vld;
    logic [1:0]  r_s2_kind;
    logic [31:0] r_s2_hi_x;
    logic [31:0] r_s2_hi_y;
    logic [31:0] r_s2_hi_z;
    logic [1:0]  r_s2_axis;
    logic [9:0]  r_s2_idx;

    logic [63:0] w_prod_x;
    logic [63:0] w_prod_y;
    logic [63:0] w_prod_z;
    logic [31:0] w_n_x;
    logic [31:0] w_n_y;
    logic [31:0] w_n_z;
    logic [31:0] w_n_sel;
    logic        w_need_push;
    logic        w_s2_ready;
    logic        w_s1_ready;
    logic        w_accept;

    // Stall chain: a stage moves when the one after it has room.
    assign w_s2_ready = !r_s2_vld || !w_need_push || !i_q_full;
    assign w_s1_ready = !r_s1_vld || w_s2_ready;
    assign o_ready    = w_s1_ready && !i_back_sts.init_busy;
    assign w_accept   = i_valid && o_ready;
    assign o_q_push   = r_s2_vld && w_need_push && !i_q_full;

    // Stage one holds the accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_vld <= w_accept;
        end
        if (w_accept) begin
            r_s1_kind  <= i_kind;
            r_s1_pos_x <= i_pos_x;
            r_s1_pos_y <= i_pos_y;
            r_s1_pos_z <= i_pos_z;
            r_s1_axis  <= i_axis;
            r_s1_idx   <= i_bin_index;
        end
    end

    // Position times reciprocal bin width; the integer part is the raw bin.
    assign w_prod_x = 64'(r_s1_pos_x) * 64'(i_cfg.inv_bin_width);
    assign w_prod_y = 64'(r_s1_pos_y) * 64'(i_cfg.inv_bin_width);
    assign w_prod_z = 64'(r_s1_pos_z) * 64'(i_cfg.inv_bin_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_vld <= r_s1_vld;
        end
        if (r_s1_vld && w_s2_ready) begin
            r_s2_kind <= r_s1_kind;
            r_s2_hi_x <= w_prod_x[63:32];
            r_s2_hi_y <= w_prod_y[63:32];
            r_s2_hi_z <= w_prod_z[63:32];
            r_s2_axis <= r_s1_axis;
            r_s2_idx  <= r_s1_idx;
        end
    end

    assign w_n_x = adh_pkg::eff_bins(i_cfg.bins_x);
    assign w_n_y = adh_pkg::eff_bins(i_cfg.bins_y);
    assign w_n_z = adh_pkg::eff_bins(i_cfg.bins_z);

    // Stage two clamps the bins, checks reads and builds the command.
    always_comb begin
        w_need_push   = 1'b0;
        w_n_sel       = w_n_x;
        o_q_cmd.op    = adh_pkg::OP_PARTICLE;
        o_q_cmd.axis  = r_s2_axis;
        o_q_cmd.oor   = 1'b0;
        o_q_cmd.bin_x = adh_pkg::BIN_BITS'((r_s2_hi_x > w_n_x - 32'd1) ?
                                           w_n_x - 32'd1 : r_s2_hi_x);
        o_q_cmd.bin_y = adh_pkg::BIN_BITS'((r_s2_hi_y > w_n_y - 32'd1) ?
                                           w_n_y - 32'd1 : r_s2_hi_y);
        o_q_cmd.bin_z = adh_pkg::BIN_BITS'((r_s2_hi_z > w_n_z - 32'd1) ?
                                           w_n_z - 32'd1 : r_s2_hi_z);
        case (r_s2_kind)
            adh_pkg::KIND_PARTICLE: begin
                w_need_push = 1'b1;
            end
            adh_pkg::KIND_READ: begin
                w_need_push   = 1'b1;
                o_q_cmd.op    = adh_pkg::OP_READ;
                o_q_cmd.bin_x = adh_pkg::BIN_BITS'(r_s2_idx);
                o_q_cmd.bin_y = adh_pkg::BIN_BITS'(r_s2_idx);
                o_q_cmd.bin_z = adh_pkg::BIN_BITS'(r_s2_idx);
                case (r_s2_axis)
                    adh_pkg::AXIS_X: begin
                        w_n_sel = w_n_x;
                        o_q_cmd.oor = (32'(r_s2_idx) >= w_n_sel);
                    end
                    adh_pkg::AXIS_Y: begin
                        w_n_sel = w_n_y;
                        o_q_cmd.oor = (32'(r_s2_idx) >= w_n_sel);
                    end
                    adh_pkg::AXIS_Z: begin
                        w_n_sel = w_n_z;
                        o_q_cmd.oor = (32'(r_s2_idx) >= w_n_sel);
                    end
                    default: begin
                        o_q_cmd.oor = 1'b1;
                    end
                endcase
            end
            adh_pkg::KIND_CLEAR: begin
                w_need_push = 1'b1;
                o_q_cmd.op  = adh_pkg::OP_CLEAR;
            end
            default: begin
                // An unused kind is dropped here.
                w_need_push = 1'b0;
            end
        endcase
    end

endmodule

[hdl/adh_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on adh_pkg.
module adh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  adh_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output adh_pkg::t_cmd o_cmd
);

    adh_pkg::t_cmd                   r_entry [adh_pkg::Q_DEPTH];
    logic [adh_pkg::Q_PTR_BITS-1:0]  r_wptr;
    logic [adh_pkg::Q_PTR_BITS-1:0]  r_rptr;
    logic [adh_pkg::Q_CNT_BITS-1:0]  r_cnt;

    localparam logic [adh_pkg::Q_PTR_BITS-1:0] PTR_LAST =
        adh_pkg::Q_PTR_BITS'(adh_pkg::Q_DEPTH - 1);
    localparam logic [adh_pkg::Q_CNT_BITS-1:0] CNT_FULL =
        adh_pkg::Q_CNT_BITS'(adh_pkg::Q_DEPTH);

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_entry[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

[hdl/adh_back.sv]
// Back end of the histogram: owns the three bin memories, runs the
// read-modify-write, read and clear sequences, and holds the result register.
// Depends on adh_pkg.
module adh_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  adh_pkg::t_cfg      i_cfg,
    input  logic               i_q_empty,
    input  adh_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output adh_pkg::t_back_sts o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_density,
    output logic [31:0]        o_count,
    output logic               o_out_of_range
);

    localparam logic [adh_pkg::BIN_BITS-1:0] ADDR_LAST =
        adh_pkg::BIN_BITS'(adh_pkg::MAX_BINS - 1);

    logic [adh_pkg::COUNT_BITS-1:0] mem_x [adh_pkg::MAX_BINS];
    logic [adh_pkg::COUNT_BITS-1:0] mem_y [adh_pkg::MAX_BINS];
    logic [adh_pkg::COUNT_BITS-1:0] mem_z [adh_pkg::MAX_BINS];

    adh_pkg::t_back_state             r_state;
    adh_pkg::t_back_state             n_state;
    adh_pkg::t_cmd                    r_cmd;
    logic [adh_pkg::COUNT_BITS-1:0]   r_rd_x;
    logic [adh_pkg::COUNT_BITS-1:0]   r_rd_y;
    logic [adh_pkg::COUNT_BITS-1:0]   r_rd_z;
    logic [adh_pkg::BIN_BITS-1:0]     r_clr_addr;
    logic [adh_pkg::BIN_BITS-1:0]     n_clr_addr;
    logic                             r_init;
    logic                             n_init;
    logic                             r_out_vld;
    logic [63:0]                      r_out_density;
    logic [31:0]                      r_out_count;
    logic                             r_out_oor;

    logic                             w_mem_we;
    logic                             w_mem_re;
    logic                             w_load_out;
    logic [adh_pkg::BIN_BITS-1:0]     w_waddr_x;
    logic [adh_pkg::BIN_BITS-1:0]     w_waddr_y;
    logic [adh_pkg::BIN_BITS-1:0]     w_waddr_z;
    logic [adh_pkg::COUNT_BITS-1:0]   w_wdata_x;
    logic [adh_pkg::COUNT_BITS-1:0]   w_wdata_y;
    logic [adh_pkg::COUNT_BITS-1:0]   w_wdata_z;
    logic [adh_pkg::COUNT_BITS-1:0]   w_sel_cnt;
    logic [31:0]                      w_sel_inv;
    logic [adh_pkg::PROD_BITS-1:0]    w_prod;

    assign o_sts.init_busy = r_init;
    assign o_valid         = r_out_vld;
    assign o_density       = r_out_density;
    assign o_count         = r_out_count;
    assign o_out_of_range  = r_out_oor;

    // State register; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= adh_pkg::BK_CLEAR;
            r_clr_addr <= '0;
            r_init     <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_init     <= n_init;
        end
    end

    // Command register, loaded as the queue head is taken.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Sequencer: next state, memory strobes and queue pop.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_init     = r_init;
        o_q_pop    = 1'b0;
        w_mem_re   = 1'b0;
        w_mem_we   = 1'b0;
        w_load_out = 1'b0;
        w_waddr_x  = r_cmd.bin_x;
        w_waddr_y  = r_cmd.bin_y;
        w_waddr_z  = r_cmd.bin_z;
        w_wdata_x  = (r_rd_x == adh_pkg::COUNT_MAX) ? r_rd_x : r_rd_x + 1'b1;
        w_wdata_y  = (r_rd_y == adh_pkg::COUNT_MAX) ? r_rd_y : r_rd_y + 1'b1;
        w_wdata_z  = (r_rd_z == adh_pkg::COUNT_MAX) ? r_rd_z : r_rd_z + 1'b1;
        case (r_state)
            adh_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    w_mem_re = 1'b1;
                    case (i_q_cmd.op)
                        adh_pkg::OP_PARTICLE: n_state = adh_pkg::BK_PART_WR;
                        adh_pkg::OP_READ:     n_state = adh_pkg::BK_READ_MUL;
                        adh_pkg::OP_CLEAR: begin
                            n_state    = adh_pkg::BK_CLEAR;
                            n_clr_addr = '0;
                        end
                        default:              n_state = adh_pkg::BK_IDLE;
                    endcase
                end
            end
            adh_pkg::BK_PART_WR: begin
                w_mem_we = 1'b1;
                n_state  = adh_pkg::BK_IDLE;
            end
            adh_pkg::BK_READ_MUL: begin
                if (!r_out_vld || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = adh_pkg::BK_IDLE;
                end
            end
            adh_pkg::BK_CLEAR: begin
                w_mem_we  = 1'b1;
                w_waddr_x = r_clr_addr;
                w_waddr_y = r_clr_addr;
                w_waddr_z = r_clr_addr;
                w_wdata_x = '0;
                w_wdata_y = '0;
                w_wdata_z = '0;
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = adh_pkg::BK_IDLE;
                    n_init  = 1'b0;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            default: begin
                n_state = adh_pkg::BK_IDLE;
            end
        endcase
    end

    // Bin memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_x[w_waddr_x] <= w_wdata_x;
            mem_y[w_waddr_y] <= w_wdata_y;
            mem_z[w_waddr_z] <= w_wdata_z;
        end
        if (w_mem_re) begin
            r_rd_x <= mem_x[i_q_cmd.bin_x];
            r_rd_y <= mem_y[i_q_cmd.bin_y];
            r_rd_z <= mem_z[i_q_cmd.bin_z];
        end
    end

    // Pick the read axis; an out-of-range read reports a zero count.
    always_comb begin
        w_sel_cnt = '0;
        w_sel_inv = '0;
        case (r_cmd.axis)
            adh_pkg::AXIS_X: begin
                w_sel_cnt = r_rd_x;
                w_sel_inv = i_cfg.inv_volume_x;
            end
            adh_pkg::AXIS_Y: begin
                w_sel_cnt = r_rd_y;
                w_sel_inv = i_cfg.inv_volume_y;
            end
            adh_pkg::AXIS_Z: begin
                w_sel_cnt = r_rd_z;
                w_sel_inv = i_cfg.inv_volume_z;
            end
            default: begin
                w_sel_cnt = '0;
            end
        endcase
        if (r_cmd.oor) begin
            w_sel_cnt = '0;
        end
    end

    assign w_prod = adh_pkg::PROD_BITS'(w_sel_cnt) * adh_pkg::PROD_BITS'(w_sel_inv);

    // Result register decouples the back end from the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_load_out) begin
            r_out_density <= 64'(w_prod);
            r_out_count   <= 32'(w_sel_cnt);
            r_out_oor     <= r_cmd.oor;
        end
    end

    // A particle taken from the queue is written back in the next cycle.
    a_part_wr_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_cmd.op == adh_pkg::OP_PARTICLE) |=>
            (r_state == adh_pkg::BK_PART_WR))
        else $error("particle pop not followed by write-back");

    // The bin memories are never read and written in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("bin memory read and write overlap");

    // The power-up sweep runs only in the clearing state.
    a_init_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_state == adh_pkg::BK_CLEAR))
        else $error("init flag set outside clearing sweep");

    // A result is only loaded into a free or draining result register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!r_out_vld || i_ready))
        else $error("result register overwritten");

endmodule

[hdl/axis_density_histogram_core.sv]
// Top level of the per-axis position histogram: configuration registers,
// front end, command queue and back end.
// Depends on adh_pkg, adh_front, adh_queue and adh_back.
//
//  Channel   Handshake               Payload
//  input     i_valid / o_ready       i_kind, i_pos_x/y/z, i_axis, i_bin_index
//  result    o_valid / i_ready       o_density, o_count, o_out_of_range
//  config    psel, penable, pwrite   paddr, pwdata, prdata (pready tied high)
//
// The front end multiplies each position into a bin, then clamps it, before
// a command reaches the queue. The back end handles a particle as a read, then
// a write of the three bin memories, and a read as a memory read, then the
// density multiply into the result register. A clear sweeps the memories one
// row a cycle through all 1024 rows. After reset the same sweep runs with
// o_ready low. A stalled result register holds reads; the queue lets
// the front end keep accepting while the back end is busy.
module axis_density_histogram_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_kind,
    input  logic [31:0]                       i_pos_x,
    input  logic [31:0]                       i_pos_y,
    input  logic [31:0]                       i_pos_z,
    input  logic [1:0]                        i_axis,
    input  logic [9:0]                        i_bin_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [63:0]                       o_density,
    output logic [31:0]                       o_count,
    output logic                              o_out_of_range,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adh_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    adh_pkg::t_cfg      r_cfg;
    adh_pkg::t_back_sts w_back_sts;
    adh_pkg::t_cmd      w_push_cmd;
    adh_pkg::t_cmd      w_head_cmd;
    logic               w_push;
    logic               w_pop;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_cfg_wr;
    logic [2:0]         w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_bin_width <= 32'd65536;
            r_cfg.bins_x        <= 11'd1024;
            r_cfg.bins_y        <= 11'd1024;
            r_cfg.bins_z        <= 11'd1024;
            r_cfg.inv_volume_x  <= 32'd0;
            r_cfg.inv_volume_y  <= 32'd0;
            r_cfg.inv_volume_z  <= 32'd0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                adh_pkg::REG_INV_BIN_WIDTH: r_cfg.inv_bin_width <= pwdata;
                adh_pkg::REG_BINS_X:        r_cfg.bins_x        <= pwdata[10:0];
                adh_pkg::REG_BINS_Y:        r_cfg.bins_y        <= pwdata[10:0];
                adh_pkg::REG_BINS_Z:        r_cfg.bins_z        <= pwdata[10:0];
                adh_pkg::REG_INV_VOLUME_X:  r_cfg.inv_volume_x  <= pwdata;
                adh_pkg::REG_INV_VOLUME_Y:  r_cfg.inv_volume_y  <= pwdata;
                adh_pkg::REG_INV_VOLUME_Z:  r_cfg.inv_volume_z  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (w_reg_idx)
            adh_pkg::REG_INV_BIN_WIDTH: prdata = r_cfg.inv_bin_width;
            adh_pkg::REG_BINS_X:        prdata = 32'(r_cfg.bins_x);
            adh_pkg::REG_BINS_Y:        prdata = 32'(r_cfg.bins_y);
            adh_pkg::REG_BINS_Z:        prdata = 32'(r_cfg.bins_z);
            adh_pkg::REG_INV_VOLUME_X:  prdata = r_cfg.inv_volume_x;
            adh_pkg::REG_INV_VOLUME_Y:  prdata = r_cfg.inv_volume_y;
            adh_pkg::REG_INV_VOLUME_Z:  prdata = r_cfg.inv_volume_z;
            default:                    prdata = 32'd0;
        endcase
    end

    adh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_back_sts  (w_back_sts),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_axis      (i_axis),
        .i_bin_index (i_bin_index),
        .i_q_full    (w_q_full),
        .o_q_push    (w_push),
        .o_q_cmd     (w_push_cmd)
    );

    adh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_head_cmd)
    );

    adh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_empty      (w_q_empty),
        .i_q_cmd        (w_head_cmd),
        .o_q_pop        (w_pop),
        .o_sts          (w_back_sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_density      (o_density),
        .o_count        (o_count),
        .o_out_of_range (o_out_of_range)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for axis_density_histogram_core: it drives requests and
// APB writes, predicts every bin read in its own histogram copy and checks the results.
// Depends on adh_pkg and axis_density_histogram_core.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves unnamed
    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam logic [1:0] AXIS_NONE    = 2'd3;

    // Run limits
    localparam int DRAIN_CYCLES = 6000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 65;
    localparam int PHASES       = 6;

    // One expected bin read
    typedef struct {
        logic [63:0] density;
        logic [31:0] count;
        logic        out_of_range;
    } t_bin_reading;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind         = adh_pkg::KIND_PARTICLE;
    logic [31:0] i_pos_x        = '0;
    logic [31:0] i_pos_y        = '0;
    logic [31:0] i_pos_z        = '0;
    logic [1:0]  i_axis         = adh_pkg::AXIS_X;
    logic [9:0]  i_bin_index    = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [63:0] o_density;
    logic [31:0] o_count;
    logic        o_out_of_range;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [adh_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    // Histogram copy and register shadow used for prediction
    logic [31:0] hist_count [0:2][0:adh_pkg::MAX_BINS-1];
    logic [31:0] cfg_width;
    logic [10:0] cfg_bins [0:2];
    logic [31:0] cfg_inv_vol [0:2];

    t_bin_reading pending_readings [$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           gaps_on = 1'b1;
    bit           stalls_on = 1'b1;

    axis_density_histogram_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_axis         (i_axis),
        .i_bin_index    (i_bin_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_density      (o_density),
        .o_count        (o_count),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // A bins register of zero means one bin; above the storage it saturates.
    function automatic logic [31:0] bins_in_use(input logic [10:0] breg);
        if (breg == 11'd0) begin
            return 32'd1;
        end else if (32'(breg) > 32'(adh_pkg::MAX_BINS)) begin
            return 32'(adh_pkg::MAX_BINS);
        end
        return 32'(breg);
    endfunction

    // Update the histogram copy for one accepted request and queue any read result.
    function automatic void predict_item(input logic [1:0] kind, input logic [31:0] px, py, pz,
                                         input logic [1:0] axis, input logic [9:0] idx);
        t_bin_reading want;
        logic [31:0]  pos [0:2];
        logic [63:0]  prod;
        logic [31:0]  n;
        logic [31:0]  bin;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        case (kind)
            adh_pkg::KIND_PARTICLE: begin
                for (int a = 0; a < 3; a++) begin
                    prod = 64'(pos[a]) * 64'(cfg_width);
                    n = bins_in_use(cfg_bins[a]);
                    bin = (prod[63:32] > n - 1) ? n - 1 : prod[63:32];
                    if (hist_count[a][bin] != adh_pkg::COUNT_MAX) begin
                        hist_count[a][bin] = hist_count[a][bin] + 1;
                    end
                end
            end
            adh_pkg::KIND_CLEAR: begin
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < adh_pkg::MAX_BINS; b++) begin
                        hist_count[a][b] = '0;
                    end
                end
            end
            adh_pkg::KIND_READ: begin
                want.density = '0;
                want.count = '0;
                want.out_of_range = 1'b1;
                if (axis != AXIS_NONE) begin
                    if (32'(idx) < bins_in_use(cfg_bins[axis])) begin
                        want.count = hist_count[axis][idx];
                        want.density = 64'(want.count) * 64'(cfg_inv_vol[axis]);
                        want.out_of_range = 1'b0;
                    end
                end
                pending_readings.push_back(want);
            end
            default: begin
                // The fourth kind is dropped by the block.
            end
        endcase
    endfunction

    // Send one request, with a random gap in front when gaps are enabled.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] px, py, pz,
                             input logic [1:0] axis, input logic [9:0] idx);
        if (gaps_on) begin
            while ($urandom_range(99) < 25) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_pos_z     <= pz;
        i_axis      <= axis;
        i_bin_index <= idx;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predict_item(kind, px, py, pz, axis, idx);
    endtask

    // Wait until every read has returned and any clears still in flight have finished.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup phase, then access phase, then an idle phase.
    task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (reg_idx)
            adh_pkg::REG_INV_BIN_WIDTH: cfg_width = value;
            adh_pkg::REG_BINS_X:        cfg_bins[0] = value[10:0];
            adh_pkg::REG_BINS_Y:        cfg_bins[1] = value[10:0];
            adh_pkg::REG_BINS_Z:        cfg_bins[2] = value[10:0];
            adh_pkg::REG_INV_VOLUME_X:  cfg_inv_vol[0] = value;
            adh_pkg::REG_INV_VOLUME_Y:  cfg_inv_vol[1] = value;
            adh_pkg::REG_INV_VOLUME_Z:  cfg_inv_vol[2] = value;
            default: begin
            end
        endcase
    endtask

    // Program the whole register set.
    task automatic apply_settings(input logic [31:0] width, input logic [10:0] bx, by, bz,
                                  input logic [31:0] vx, vy, vz);
        write_reg(adh_pkg::REG_INV_BIN_WIDTH, width);
        write_reg(adh_pkg::REG_BINS_X, 32'(bx));
        write_reg(adh_pkg::REG_BINS_Y, 32'(by));
        write_reg(adh_pkg::REG_BINS_Z, 32'(bz));
        write_reg(adh_pkg::REG_INV_VOLUME_X, vx);
        write_reg(adh_pkg::REG_INV_VOLUME_Y, vy);
        write_reg(adh_pkg::REG_INV_VOLUME_Z, vz);
    endtask

    // Report one field that differs from the prediction.
    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Position that lands in or near a chosen bin, so that counts pile up.
    function automatic logic [31:0] random_pos(input int a);
        logic [31:0] n;
        logic [31:0] hi;
        logic [31:0] target;
        logic [63:0] num;
        logic [63:0] q;
        if ($urandom_range(99) < 25 || cfg_width == 32'd0) begin
            return $urandom();
        end
        n = bins_in_use(cfg_bins[a]);
        hi = (n < 8) ? n : 32'd8;
        target = ($urandom_range(1) == 1) ? $urandom_range(hi, 0) : $urandom_range(n + 1, 0);
        num = {target, $urandom()};
        q = num / 64'(cfg_width);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Bin index to read, mostly among the low bins where counts collect.
    function automatic logic [9:0] random_index(input logic [1:0] axis);
        logic [31:0] n;
        logic [31:0] hi;
        int unsigned r;
        n = (axis == AXIS_NONE) ? 32'(adh_pkg::MAX_BINS) : bins_in_use(cfg_bins[axis]);
        hi = (n < 8) ? n : 32'd8;
        r = $urandom_range(99);
        if (r < 50) begin
            return 10'($urandom_range(hi - 1, 0));
        end else if (r < 80) begin
            return 10'($urandom_range(n - 1, 0));
        end
        return 10'($urandom());
    endfunction

    // Compare each returned result with the oldest prediction; stall at random.
    always @(posedge i_clk) begin : result_check
        t_bin_reading want;
        if (o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: result with no read pending, expected none, actual %h %h %b",
                         $time, o_density, o_count, o_out_of_range);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                check_field("density", want.density, o_density);
                check_field("count", 64'(want.count), 64'(o_count));
                check_field("out_of_range", 64'(want.out_of_range), 64'(o_out_of_range));
            end
        end
        i_ready <= stalls_on ? ($urandom_range(99) >= 25) : 1'b1;
    end

    // Global timeout.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // After reset sample bins of each axis read as zero with the default registers.
    task automatic test_reset_state();
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Y, 10'd1023);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd512);
        settle();
    endtask

    // Zero and full-scale positions, clamping to the last bin, every axis and the ignored codes.
    task automatic test_particle_extremes();
        apply_settings(32'h0001_0000, 11'd1024, 11'd1024, 11'd1024,
                       32'hFFFF_FFFF, 32'd1, 32'h8000_0000);
        send_item(adh_pkg::KIND_PARTICLE, 32'h0, 32'h0, 32'h0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_PARTICLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_PARTICLE, 32'h0005_8000, 32'h03FF_FFFF, 32'h0400_0000,
                  adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd1023);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd5);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Y, 10'd1023);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd1023);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Y, 10'd0);
        // Axis code three selects no histogram.
        send_item(adh_pkg::KIND_READ, '0, '0, '0, AXIS_NONE, 10'd0);
        // The fourth kind must change nothing and return nothing.
        send_item(KIND_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AXIS_NONE, 10'h3FF);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd0);
    endtask

    // A clear empties every bin of every axis.
    task automatic test_clear();
        send_item(adh_pkg::KIND_CLEAR, '0, '0, '0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd1023);
        settle();
    endtask

    // Bin count registers of zero and above the storage, with the widest bin scale.
    task automatic test_bin_count_limits();
        apply_settings(32'hFFFF_FFFF, 11'd0, 11'd2047, 11'd1,
                       32'h1234_5678, 32'hFFFF_FFFF, 32'd0);
        send_item(adh_pkg::KIND_PARTICLE, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                  adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_X, 10'd1);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Y, 10'd1023);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd0);
        send_item(adh_pkg::KIND_READ, '0, '0, '0, adh_pkg::AXIS_Z, 10'd1);
        settle();
    endtask

    // Random register settings per phase, then a random mix of requests.
    task automatic test_random_phases();
        logic [31:0] width;
        logic [10:0] phase_bins [0:2];
        logic [31:0] vols [0:2];
        logic [1:0]  axis;
        int          sent;
        int unsigned r;
        for (int phase = 0; phase < PHASES; phase++) begin
            // The first phase runs with no gaps and no stalls at all.
            gaps_on = (phase != 0);
            stalls_on = (phase != 0);
            case ($urandom_range(7))
                0:       width = 32'd0;
                1:       width = 32'd1;
                2:       width = 32'hFFFF_FFFF;
                3:       width = 32'h0001_0000;
                4:       width = $urandom();
                default: width = $urandom_range(32'h0008_0000, 32'h0000_1000);
            endcase
            for (int a = 0; a < 3; a++) begin
                case ($urandom_range(7))
                    0:       phase_bins[a] = 11'd0;
                    1:       phase_bins[a] = 11'd1;
                    2:       phase_bins[a] = 11'd2047;
                    3:       phase_bins[a] = 11'd1024;
                    4, 5:    phase_bins[a] = 11'($urandom_range(16, 1));
                    6:       phase_bins[a] = 11'($urandom_range(2047, 1));
                    default: phase_bins[a] = 11'($urandom_range(2047, 1025));
                endcase
                case ($urandom_range(3))
                    0:       vols[a] = 32'd0;
                    1:       vols[a] = 32'hFFFF_FFFF;
                    default: vols[a] = $urandom();
                endcase
            end
            apply_settings(width, phase_bins[0], phase_bins[1], phase_bins[2],
                           vols[0], vols[1], vols[2]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    send_item(adh_pkg::KIND_PARTICLE, random_pos(0), random_pos(1),
                              random_pos(2), 2'($urandom()), 10'($urandom()));
                    sent++;
                end else if (r < 90) begin
                    axis = ($urandom_range(19) == 0) ? AXIS_NONE : 2'($urandom_range(2));
                    send_item(adh_pkg::KIND_READ, $urandom(), $urandom(), $urandom(),
                              axis, random_index(axis));
                    sent++;
                end else if (r < 92) begin
                    send_item(adh_pkg::KIND_CLEAR, $urandom(), $urandom(), $urandom(),
                              2'($urandom()), 10'($urandom()));
                    sent++;
                end else begin
                    send_item(KIND_IGNORED, $urandom(), $urandom(), $urandom(),
                              2'($urandom()), 10'($urandom()));
                end
            end
            settle();
        end
    endtask

    // Test sequence.
    initial begin
        cfg_width = 32'h0001_0000;
        for (int a = 0; a < 3; a++) begin
            cfg_bins[a] = 11'd1024;
            cfg_inv_vol[a] = 32'd0;
            for (int b = 0; b < adh_pkg::MAX_BINS; b++) begin
                hist_count[a][b] = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_particle_extremes();
        test_clear();
        test_bin_count_limits();
        test_random_phases();
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hdl/adh_pkg.sv
hdl/adh_front.sv
hdl/adh_queue.sv
hdl/adh_back.sv
hdl/axis_density_histogram_core.sv
tb/sv/tb_top.sv
